// ===== rtl/gb3_pkg.sv =====
// ----------------------------------------------------------------------------
// gb3_pkg: shared types and constants for the 3x3 Gaussian raster filter
// Pixel and window column types, per-axis tap weighting modes and the
// result slot codes used by the window stage.
// ----------------------------------------------------------------------------
`default_nettype none

package gb3_pkg;

	// Default largest image side and the image size after reset.
	localparam int MAX_SIZE_DEFAULT = 4096;
	localparam int SIZE_RESET       = 4096;

	// Width of the image size register as seen on the configuration port.
	localparam int CFG_W = 13;

	// Widths of the vertical (one column) and full window weighted sums.
	localparam int VSUM_W = 10;
	localparam int HSUM_W = 12;

	// floor(x * RECIP9 / 2**16) equals floor(x / 9) for every x below 32768.
	localparam int RECIP_W = 25;
	localparam logic [RECIP_W-1:0] RECIP9 = 25'd7282;

	typedef logic [7:0] pix_t;

	// One window column; element 0 is the oldest row, element 2 the newest.
	typedef pix_t [2:0] col_t;

	// Tap weight 0..3 along one axis.
	typedef logic [1:0] wt_t;

	typedef struct packed {
		wt_t w2;
		wt_t w1;
		wt_t w0;
	} wvec_t;

	// How the three taps of one axis are used.
	//   AX_FULL:        all three taps, weights 1 2 1.
	//   AX_LO_OUT:      oldest tap lies outside the image, centered on the middle tap.
	//   AX_HI_OUT:      tap past the newest lies outside, centered on the newest tap.
	//   AX_HI_OUT_PREV: tap past the middle lies outside, centered on the middle tap.
	typedef enum logic [1:0] {
		AX_FULL,
		AX_LO_OUT,
		AX_HI_OUT,
		AX_HI_OUT_PREV
	} axis_t;

	// Results one input pixel can cause, in delivery order.
	typedef enum logic [1:0] {
		SLOT_FIRST,
		SLOT_BELOW,
		SLOT_RIGHT,
		SLOT_CORNER
	} slot_t;

	// Tap weights for one axis. Non-corner pixels replicate the center tap
	// into the outside one; corner pixels drop the outside tap.
	function automatic wvec_t axis_weights(input axis_t mode, input logic corner);
		wvec_t w;
		w.w0 = 2'd1;
		w.w1 = 2'd2;
		w.w2 = 2'd1;
		case (mode)
			AX_FULL: begin
				w.w0 = 2'd1;
				w.w1 = 2'd2;
				w.w2 = 2'd1;
			end
			AX_LO_OUT: begin
				w.w0 = 2'd0;
				w.w1 = corner ? 2'd2 : 2'd3;
				w.w2 = 2'd1;
			end
			AX_HI_OUT: begin
				w.w0 = 2'd0;
				w.w1 = 2'd1;
				w.w2 = corner ? 2'd2 : 2'd3;
			end
			AX_HI_OUT_PREV: begin
				w.w0 = 2'd1;
				w.w1 = corner ? 2'd2 : 2'd3;
				w.w2 = 2'd0;
			end
			default: begin
				w.w0 = 2'd1;
				w.w1 = 2'd2;
				w.w2 = 2'd1;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gb3_line.sv =====
// ----------------------------------------------------------------------------
// gb3_line: one image row of pixel storage
// Single write port and one read port with registered read data. A read
// and a write to the same address in one cycle return the old entry.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_line #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic           clk,
	input  wire logic           wr_en,
	input  wire logic [AW-1:0]  wr_addr,
	input  wire gb3_pkg::pix_t  wr_data,
	input  wire logic           rd_en,
	input  wire logic [AW-1:0]  rd_addr,
	output gb3_pkg::pix_t       rd_data
);
	import gb3_pkg::*;

	pix_t mem [DEPTH];
	pix_t rd_data_q;

	// Storage array; a read that meets a write to its address sees the old entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/gb3_cell.sv =====
// ----------------------------------------------------------------------------
// gb3_cell: one column of the 3x3 window
// Holds three pixels of one column, hands them to the next older column on
// each shift and forms the column's vertically weighted sum.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          shift_en,
	input  wire gb3_pkg::col_t                 col_in,
	output gb3_pkg::col_t                      col_out,
	input  wire gb3_pkg::wvec_t                wts,
	output logic [gb3_pkg::VSUM_W-1:0]         vsum
);
	import gb3_pkg::*;

	col_t col_q;

	// Small weight times pixel, built from a shift and an add.
	function automatic logic [VSUM_W-1:0] wmul(input wt_t w, input pix_t p);
		logic [VSUM_W-1:0] x;
		logic [VSUM_W-1:0] r;
		x = VSUM_W'(p);
		case (w)
			2'd0:    r = '0;
			2'd1:    r = x;
			2'd2:    r = x << 1;
			2'd3:    r = x + (x << 1);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Column register, loaded from the newer neighbor on each shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	// Vertical weighted sum over the three rows of this column.
	assign vsum = wmul(wts.w0, col_q[0]) + wmul(wts.w1, col_q[1]) + wmul(wts.w2, col_q[2]);

endmodule

`default_nettype wire

// ===== rtl/gaussian_3x3_raster_filter_top.sv =====
// ----------------------------------------------------------------------------
// gaussian_3x3_raster_filter_top: 3x3 Gaussian blur over a raster image
// Two row stores feed a chain of three column cells that forms the window;
// each input pixel releases up to four filtered pixels in raster order.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    s_tdata: pixel_in
// m_*       out        m_tvalid / m_tready    m_tdata: pixel_out, m_tlast: run_last,
//                                             m_tuser: frame_end
// cfg_*     in         cfg_valid / cfg_ready  cfg_data: image_size
//
// One pixel is taken per clock while each input causes at most one result and
// the output does not stall. On the last image row every pixel after the first
// causes two results and the final pixel four, so the single output port sets
// the pace there. Reset clears the counters and sets the image size to its
// maximum, capped at SIZE_RESET. An output stall fills the internal stages
// before the input stops.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_3x3_raster_filter_top #(
	parameter int MAX_SIZE = gb3_pkg::MAX_SIZE_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// Configuration write.
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [gb3_pkg::CFG_W-1:0] cfg_data,   // [12:0] image_size
	// Source pixels.
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [7:0]                s_tdata,    // [7:0] pixel_in
	// Filtered pixels.
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [7:0]                     m_tdata,    // [7:0] pixel_out
	output logic                           m_tlast,    // run_last
	output logic                           m_tuser     // [0] frame_end
);
	import gb3_pkg::*;

	localparam int SZW      = $clog2(MAX_SIZE + 1);
	localparam int CW       = $clog2(MAX_SIZE);
	localparam int CMPW     = (SZW > CFG_W) ? SZW : CFG_W;
	localparam int RST_SIZE = (MAX_SIZE < SIZE_RESET) ? MAX_SIZE : SIZE_RESET;

	// Image size and position of the next input pixel.
	logic [SZW-1:0]  size_q;
	logic [CW-1:0]   col_q;
	logic [CW-1:0]   row_q;
	logic [SZW-1:0]  size_m1;
	logic [SZW-1:0]  size_cfg;
	logic [CMPW-1:0] cfg_ext;
	logic            col_last;
	logic            row_last;

	// Handshakes between stages.
	logic in_fire;
	logic s1_go;
	logic s2_load;
	logic emit;
	logic s3_ready;
	logic s3_go;
	logic out_ready;

	// Stage 1: captured pixel and its result plan; row store reads in flight.
	logic           v_s1;
	pix_t           px_s1;
	logic [CW-1:0]  col_s1;
	logic [3:0]     mask_s1;
	logic           top_out_s1;
	logic           left_out_s1;
	logic           rc_s1;
	logic           rc_in;
	logic           main_in;
	logic           lrow_in;
	pix_t           upper_rd;
	pix_t           lower_rd;

	// Stage 2: window in the cells and the results still owed by its pixel.
	logic [3:0]     mask_s2;
	logic           top_out_s2;
	logic           left_out_s2;
	logic           rc_s2;
	slot_t          slot;
	logic [3:0]     slot_bit;
	logic [3:0]     remain;
	axis_t          row_mode;
	axis_t          col_mode;
	logic           corner;
	wvec_t          row_w;
	wvec_t          col_w;
	col_t           chain [0:3];
	logic [VSUM_W-1:0] vsum [0:2];
	logic [HSUM_W-1:0] hsum;

	// Stage 3: weighted sum awaiting its divide.
	logic              v_s3;
	logic [HSUM_W-1:0] sum_s3;
	logic              corner_s3;
	logic              last_s3;
	logic              fe_s3;
	logic [RECIP_W-1:0] prod9;
	pix_t              quot;

	// Output register.
	logic m_tvalid_q;
	pix_t pixel_out_q;
	logic run_last_q;
	logic frame_end_q;

	// Weight times column sum.
	function automatic logic [HSUM_W-1:0] hmul(input wt_t w, input logic [VSUM_W-1:0] v);
		logic [HSUM_W-1:0] x;
		logic [HSUM_W-1:0] r;
		x = HSUM_W'(v);
		case (w)
			2'd0:    r = '0;
			2'd1:    r = x;
			2'd2:    r = x << 1;
			2'd3:    r = x + (x << 1);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Handshake chain from the output back to the input.
	assign cfg_ready = 1'b1;
	assign out_ready = !m_tvalid_q || m_tready;
	assign s3_go     = v_s3 && out_ready;
	assign s3_ready  = !v_s3 || out_ready;
	assign emit      = (mask_s2 != 4'd0) && s3_ready;
	assign s2_load   = (mask_s2 == 4'd0) || (emit && (remain == 4'd0));
	assign s1_go     = v_s1 && s2_load;
	assign s_tready  = !v_s1 || s2_load;
	assign in_fire   = s_tvalid && s_tready;

	// Clamp of a written image size into the supported range.
	always_comb begin
		cfg_ext = CMPW'(cfg_data);
		if (cfg_ext < CMPW'(2)) begin
			size_cfg = SZW'(2);
		end else if (cfg_ext > CMPW'(MAX_SIZE)) begin
			size_cfg = SZW'(MAX_SIZE);
		end else begin
			size_cfg = SZW'(cfg_ext);
		end
	end

	assign size_m1  = size_q - SZW'(1);
	assign col_last = (SZW'(col_q) == size_m1);
	assign row_last = (SZW'(row_q) == size_m1);

	// Position counters; a size write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SZW'(RST_SIZE);
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_valid) begin
			size_q <= size_cfg;
			col_q  <= '0;
			row_q  <= '0;
		end else if (in_fire) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Result plan of the incoming pixel.
	assign rc_in   = (col_q == '0) && (SZW'(row_q) >= SZW'(2));
	assign main_in = (col_q != '0) && (row_q != '0);
	assign lrow_in = main_in && row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1       <= s_tdata;
			col_s1      <= col_q;
			mask_s1     <= {lrow_in && col_last, lrow_in && col_last, lrow_in, rc_in || main_in};
			top_out_s1  <= rc_in ? (SZW'(row_q) == SZW'(2)) : (SZW'(row_q) == SZW'(1));
			left_out_s1 <= (SZW'(col_q) == SZW'(1));
			rc_s1       <= rc_in;
		end
	end

	// Row stores: lower holds the previous row, upper the one before it.
	gb3_line #(
		.DEPTH (MAX_SIZE),
		.AW    (CW)
	) u_line_lower (
		.clk     (clk),
		.wr_en   (in_fire),
		.wr_addr (col_q),
		.wr_data (s_tdata),
		.rd_en   (in_fire),
		.rd_addr (col_q),
		.rd_data (lower_rd)
	);

	gb3_line #(
		.DEPTH (MAX_SIZE),
		.AW    (CW)
	) u_line_upper (
		.clk     (clk),
		.wr_en   (s1_go),
		.wr_addr (col_s1),
		.wr_data (lower_rd),
		.rd_en   (in_fire),
		.rd_addr (col_q),
		.rd_data (upper_rd)
	);

	// Newest window column enters the chain at its top end.
	assign chain[3] = {px_s1, lower_rd, upper_rd};

	// Chain of column cells, oldest column at index 0.
	for (genvar i = 0; i < 3; i++) begin : g_cell
		gb3_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (s1_go),
			.col_in   (chain[i+1]),
			.col_out  (chain[i]),
			.wts      (row_w),
			.vsum     (vsum[i])
		);
	end

	// Results owed by the pixel now in the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= 4'd0;
		end else if (s1_go) begin
			mask_s2 <= mask_s1;
		end else if (emit) begin
			mask_s2 <= remain;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			top_out_s2  <= top_out_s1;
			left_out_s2 <= left_out_s1;
			rc_s2       <= rc_s1;
		end
	end

	// Pick the oldest owed result.
	always_comb begin
		if (mask_s2[0]) begin
			slot = SLOT_FIRST;
		end else if (mask_s2[1]) begin
			slot = SLOT_BELOW;
		end else if (mask_s2[2]) begin
			slot = SLOT_RIGHT;
		end else begin
			slot = SLOT_CORNER;
		end
		slot_bit = 4'd1 << slot;
		remain   = mask_s2 & ~slot_bit;
	end

	// Tap use along rows and columns for the chosen result.
	always_comb begin
		case (slot)
			SLOT_FIRST: begin
				row_mode = top_out_s2 ? AX_LO_OUT : AX_FULL;
				if (rc_s2) begin
					col_mode = AX_HI_OUT_PREV;
				end else begin
					col_mode = left_out_s2 ? AX_LO_OUT : AX_FULL;
				end
			end
			SLOT_BELOW: begin
				row_mode = AX_HI_OUT;
				col_mode = left_out_s2 ? AX_LO_OUT : AX_FULL;
			end
			SLOT_RIGHT: begin
				row_mode = top_out_s2 ? AX_LO_OUT : AX_FULL;
				col_mode = AX_HI_OUT;
			end
			SLOT_CORNER: begin
				row_mode = AX_HI_OUT;
				col_mode = AX_HI_OUT;
			end
			default: begin
				row_mode = AX_FULL;
				col_mode = AX_FULL;
			end
		endcase
		corner = (row_mode != AX_FULL) && (col_mode != AX_FULL);
		row_w  = axis_weights(row_mode, corner);
		col_w  = axis_weights(col_mode, corner);
	end

	// Horizontal combine of the three column sums.
	assign hsum = hmul(col_w.w0, vsum[0]) + hmul(col_w.w1, vsum[1]) + hmul(col_w.w2, vsum[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (emit) begin
			v_s3 <= 1'b1;
		end else if (s3_go) begin
			v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sum_s3    <= hsum;
			corner_s3 <= corner;
			last_s3   <= (remain == 4'd0);
			fe_s3     <= (slot == SLOT_CORNER);
		end
	end

	// Divide by 9 for corners, by 16 elsewhere.
	assign prod9 = RECIP_W'(sum_s3) * RECIP9;
	assign quot  = corner_s3 ? prod9[23:16] : sum_s3[11:4];

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s3_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_go) begin
			pixel_out_q <= quot;
			run_last_q  <= last_s3;
			frame_end_q <= fe_s3;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = pixel_out_q;
	assign m_tlast  = run_last_q;
	assign m_tuser  = frame_end_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 3x3 Gaussian raster filter
// A predictor inside the scoreboard keeps its own row stores, window and
// raster position. It works out every filtered pixel that an accepted source
// pixel releases, and each result from the block is checked in order. The
// stimulus covers tiny frames with extreme pixels, size clamping, a frame that
// is abandoned partway, back-to-back frames and a partial frame at the largest
// size. Random frames follow, with stalls on both streams.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gb3_pkg::*;

	localparam int LARGEST       = MAX_SIZE_DEFAULT;
	localparam int OFF_IMAGE     = -1;   // tap selector for a row or column outside the image
	localparam int KERNEL_NORM   = 16;
	localparam int CORNER_NORM   = 9;
	localparam int SETTLE_CYCLES = 8;    // covers the pipeline with margin
	localparam int STALL_LIMIT   = 1000;
	localparam int RANDOM_PIXELS = 32;
	localparam int CLAMP_PIXELS  = 6;
	localparam int CALM_SIDE     = 6;

	typedef struct packed {
		pix_t pixel;
		logic run_last;
		logic frame_end;
	} blur_result_t;

	// Scoreboard with a built-in predictor of the filter.
	class blur_scoreboard;
		pix_t upper_row[LARGEST];
		pix_t lower_row[LARGEST];
		pix_t win[9];
		int unsigned col;
		int unsigned row;
		int unsigned side;
		int unsigned mismatches;
		blur_result_t expected_pixels[$];

		function new();
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				lower_row[i] = '0;
			end
			foreach (win[i])
				win[i] = '0;
			col = 0;
			row = 0;
			side = (SIZE_RESET > LARGEST) ? LARGEST : SIZE_RESET;
			mismatches = 0;
		endfunction

		function int unsigned pending();
			return expected_pixels.size();
		endfunction

		// A size write clamps the value and restarts the frame.
		function void apply_size(logic [CFG_W-1:0] value);
			if (value < 2)
				side = 2;
			else if (value > LARGEST)
				side = LARGEST;
			else
				side = value;
			col = 0;
			row = 0;
		endfunction

		// Weighted window sum. Edges replicate the middle tap; corners drop
		// the outside taps and normalize by the remaining weight.
		function pix_t weighted_blur(int rt, int rm, int rb, int cl, int cm, int cr);
			int unsigned wt[3];
			int rows[3];
			int cols[3];
			int r;
			int c;
			bit corner;
			int unsigned acc;
			wt = '{1, 2, 1};
			rows = '{rt, rm, rb};
			cols = '{cl, cm, cr};
			corner = (rt == OFF_IMAGE || rb == OFF_IMAGE) &&
				(cl == OFF_IMAGE || cr == OFF_IMAGE);
			acc = 0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					r = rows[i];
					c = cols[j];
					if (corner && (r == OFF_IMAGE || c == OFF_IMAGE))
						continue;
					if (r == OFF_IMAGE)
						r = rm;
					if (c == OFF_IMAGE)
						c = cm;
					acc += wt[i] * wt[j] * win[r * 3 + c];
				end
			end
			return corner ? pix_t'(acc / CORNER_NORM) : pix_t'(acc / KERNEL_NORM);
		endfunction

		function void expect_pixel(pix_t value, logic fend);
			expected_pixels.push_back('{pixel: value, run_last: 1'b0, frame_end: fend});
		endfunction

		// Updates the window and stores for one source pixel and queues the
		// filtered pixels it releases.
		function void note_pixel(pix_t px);
			int unsigned r;
			int unsigned c;
			int unsigned queued;
			int top;
			int left;
			r = row;
			c = col;
			queued = expected_pixels.size();

			// Right-column result of row r-2, taken before the window shifts.
			if (c == 0 && r >= 2)
				expect_pixel(weighted_blur((r == 2) ? OFF_IMAGE : 0, 1, 2, 1, 2, OFF_IMAGE), 1'b0);

			for (int i = 0; i < 3; i++) begin
				win[i * 3]     = win[i * 3 + 1];
				win[i * 3 + 1] = win[i * 3 + 2];
			end
			win[2] = upper_row[c];
			win[5] = lower_row[c];
			win[8] = px;
			upper_row[c] = lower_row[c];
			lower_row[c] = px;

			if (c >= 1 && r >= 1) begin
				top = (r == 1) ? OFF_IMAGE : 0;
				left = (c == 1) ? OFF_IMAGE : 0;
				expect_pixel(weighted_blur(top, 1, 2, left, 1, 2), 1'b0);
				// The last input row also flushes the bottom output row.
				if (r == side - 1) begin
					expect_pixel(weighted_blur(1, 2, OFF_IMAGE, left, 1, 2), 1'b0);
					if (c == side - 1) begin
						expect_pixel(weighted_blur(top, 1, 2, 1, 2, OFF_IMAGE), 1'b0);
						expect_pixel(weighted_blur(1, 2, OFF_IMAGE, 1, 2, OFF_IMAGE), 1'b1);
					end
				end
			end
			if (expected_pixels.size() > queued)
				expected_pixels[expected_pixels.size() - 1].run_last = 1'b1;

			c++;
			if (c >= side) begin
				c = 0;
				r++;
				if (r >= side)
					r = 0;
			end
			col = c;
			row = r;
		endfunction

		// Compares one filtered pixel with the oldest expectation.
		function void check_result(pix_t px, logic last, logic fend);
			blur_result_t want;
			if (expected_pixels.size() == 0) begin
				$error("pixel_out %0d arrived with no result expected", px);
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			if (px !== want.pixel) begin
				$error("pixel_out: expected %0d, actual %0d", want.pixel, px);
				mismatches++;
			end
			if (last !== want.run_last) begin
				$error("run_last: expected %0b, actual %0b", want.run_last, last);
				mismatches++;
			end
			if (fend !== want.frame_end) begin
				$error("frame_end: expected %0b, actual %0b", want.frame_end, fend);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tlast;
	logic             m_tuser;

	blur_scoreboard sb;
	bit             calm = 1'b0;
	int             quiet_cycles = 0;

	gaussian_3x3_raster_filter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The result sink stalls at random unless a calm stretch is running.
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 29);
	end

	// Observe every transfer on the three channels and track quiet cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.apply_size(cfg_data);
			if (s_tvalid && s_tready)
				sb.note_pixel(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tlast, m_tuser);
			if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Watchdog: too long without any transfer ends the run.
	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// One source pixel, with random gaps before it.
	task automatic send_pixel(input pix_t px);
		while (!calm && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Holds the source until every expected result has come; returns at a
	// rising edge.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Writes the image size once the block has gone idle.
	task automatic write_size(input logic [CFG_W-1:0] value);
		wait_for_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random pixels with a bias toward the extremes and rare mid-frame pauses.
	task automatic stream_pixels(input int count);
		pix_t px;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(9))
				0: px = 8'h00;
				1: px = 8'hFF;
				default: px = pix_t'($urandom_range(255));
			endcase
			if (!calm && $urandom_range(39) == 0)
				wait_for_results();
			send_pixel(px);
		end
	endtask

	// Main stimulus.
	initial begin
		int unsigned sent;
		int unsigned edge_len;
		int unsigned count;
		bit broken;
		sb = new();
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		calm = 1'b0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A size of zero clamps to the smallest frame.
		write_size('0);
		for (int k = 0; k < 4; k++)
			send_pixel((k == 1 || k == 2) ? 8'hFF : 8'h00);

		// A size of one clamps as well; all pixels at full scale.
		write_size(13'd1);
		for (int k = 0; k < 4; k++)
			send_pixel(8'hFF);

		// A 3x3 checkerboard of extremes.
		write_size(13'd3);
		for (int k = 0; k < 9; k++)
			send_pixel((k % 2) ? 8'hFF : 8'h00);

		// Abandon a frame partway; the next size write restarts the raster.
		write_size(13'd3);
		for (int k = 0; k < 5; k++)
			send_pixel((k % 2) ? 8'h00 : 8'hFF);

		// Two 2x2 frames back to back, so the raster wraps.
		write_size(13'd2);
		for (int k = 0; k < 8; k++)
			send_pixel((k % 3 == 0) ? 8'hFF : 8'h5A);

		// A size beyond the maximum clamps to it; its first row releases nothing.
		write_size({CFG_W{1'b1}});
		stream_pixels(CLAMP_PIXELS);

		// One whole frame with neither side idling.
		write_size(CFG_W'(CALM_SIDE));
		calm = 1'b1;
		stream_pixels(CALM_SIDE * CALM_SIDE);
		calm = 1'b0;

		// Random frames, some of them cut short.
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			edge_len = ($urandom_range(7) == 0) ? $urandom_range(6, 8) : $urandom_range(2, 5);
			write_size(CFG_W'(edge_len));
			for (int f = $urandom_range(1, 2); f > 0; f--) begin
				count = edge_len * edge_len;
				broken = ($urandom_range(4) == 0);
				if (broken)
					count = $urandom_range(1, count - 1);
				stream_pixels(count);
				sent += count;
				if (broken)
					break;
			end
		end

		wait_for_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/gb3_pkg.sv
rtl/gb3_line.sv
rtl/gb3_cell.sv
rtl/gaussian_3x3_raster_filter_top.sv
tb/testbench.sv
